// File: design/pdew_pkg.sv
// shared types and constants for the per-destination ewma window table
`default_nettype none

package pdew_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned ACK_W    = 40;
  localparam int unsigned MSS_W    = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned EST_W    = 24;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned CFG_W    = 40;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FLOOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CEILING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ACKED_BYTES = 2'd3;

  localparam logic [WIN_W-1:0]   FLOOR_RST   = 16'd10;
  localparam logic [WIN_W-1:0]   CEILING_RST = 16'd100;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 4'd2;
  localparam logic [ACK_W-1:0]   MIN_ACK_RST = 40'd4096;

  typedef struct packed {
    logic [KEY_W-1:0] dest_addr;
    logic [WIN_W-1:0] peak_cwnd;
    logic [ACK_W-1:0] acked_bytes;
    logic [MSS_W-1:0] segment_size;
  } item_t;

  typedef struct packed {
    logic [WIN_W-1:0] new_window;
    logic             discarded;
    logic             table_full;
    logic [WIN_W-1:0] held_window;
    logic [WIN_W-1:0] estimate_after;
    logic [CNT_W-1:0] sample_count;
    logic [CNT_W-1:0] discard_count;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] samples;
    logic [CNT_W-1:0] discards;
    logic [EST_W-1:0] estimate;
    logic [WIN_W-1:0] window;
  } entry_t;

endpackage

`default_nettype wire

// File: design/pdew_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module pdew_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/pdew_div.sv
// bit-serial restoring divider for the segment count
`default_nettype none

module pdew_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pdew_pkg::ACK_W-1:0]  dividend_i,
  input  wire logic [pdew_pkg::MSS_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [pdew_pkg::ACK_W-1:0]  quot_o,
  output logic                             rem_nz_o
);

  localparam int unsigned QW  = pdew_pkg::ACK_W;
  localparam int unsigned DW  = pdew_pkg::MSS_W;
  localparam int unsigned CW  = $clog2(QW + 1);
  localparam logic [CW-1:0] STEPS = CW'(QW);

  logic [QW-1:0] quot_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;

  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          ge;

  assign shifted = {rem_q, quot_q[QW-1]};
  assign trial   = shifted - {1'b0, divisor_i};
  assign ge      = (shifted >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= STEPS;
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (run_q) begin
      quot_q <= {quot_q[QW-2:0], ge};
      rem_q  <= ge ? trial[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

// File: design/per_destination_ewma_window_core.sv
// top level: per-destination smoothed window table with serial search and divide
`default_nettype none

// A record is taken on start_i while busy_o is low, and exactly one result word
// follows on result_o with done_o high for one cycle; the receiver cannot stall,
// so it must take the word in that cycle. busy_o stays high through the key search,
// which reads one claimed entry per cycle from the table ram, through the
// bit-serial divider when the record is sampled with a nonzero segment size, and
// through the prepare, update and write-back steps that the record needs. The word
// comes in the cycle after write-back, in which the next record can already be
// taken. Claimed entries fill the table from the bottom, so a fill count stands in
// for clearing and no pass is run after reset. Configuration writes take effect at
// once and belong in idle time.
module per_destination_ewma_window_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire pdew_pkg::item_t                   item_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output pdew_pkg::result_t                      result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [pdew_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [pdew_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(TABLE_DEPTH);
  localparam int unsigned EW = $bits(pdew_pkg::entry_t);
  localparam int unsigned KW = pdew_pkg::KEY_W;
  localparam int unsigned WW = pdew_pkg::WIN_W;
  localparam int unsigned AKW = pdew_pkg::ACK_W;
  localparam int unsigned XW = pdew_pkg::EST_W;
  localparam int unsigned FW = pdew_pkg::FRAC_W;
  localparam int unsigned NW = pdew_pkg::CNT_W;
  localparam int unsigned SW = pdew_pkg::SHIFT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_UPD    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // configuration
  logic [WW-1:0]  floor_q;
  logic [WW-1:0]  ceil_q;
  logic [SW-1:0]  shift_q;
  logic [AKW-1:0] min_ack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= pdew_pkg::FLOOR_RST;
      ceil_q    <= pdew_pkg::CEILING_RST;
      shift_q   <= pdew_pkg::SHIFT_RST;
      min_ack_q <= pdew_pkg::MIN_ACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pdew_pkg::REG_WINDOW_FLOOR:    floor_q   <= cfg_wdata_i[WW-1:0];
        pdew_pkg::REG_WINDOW_CEILING:  ceil_q    <= cfg_wdata_i[WW-1:0];
        pdew_pkg::REG_SMOOTHING_SHIFT: shift_q   <= cfg_wdata_i[SW-1:0];
        pdew_pkg::REG_MIN_ACKED_BYTES: min_ack_q <= cfg_wdata_i[AKW-1:0];
        default: ;
      endcase
    end
  end

  // control and working registers
  logic [2:0]            state_q;
  logic [AW:0]           fill_q;
  logic [AW:0]           idx_q;
  logic                  pend_q;
  logic [AW-1:0]         cmp_idx_q;
  logic                  zvalid_q;
  logic                  done_q;
  logic                  full_q;
  logic                  sampled_q;
  logic [AW-1:0]         slot_q;
  pdew_pkg::item_t       item_q;
  pdew_pkg::entry_t      rec_q;
  pdew_pkg::entry_t      zrec_q;
  pdew_pkg::result_t     result_q;
  pdew_pkg::result_t     result_d;
  logic [WW-1:0]         sample_q;

  // table ram
  logic [EW-1:0]         rd_data;
  pdew_pkg::entry_t      rd_entry;
  logic                  ram_we;
  pdew_pkg::entry_t      wr_entry;

  assign rd_entry = pdew_pkg::entry_t'(rd_data);

  pdew_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr_entry),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // divider
  logic            div_start;
  logic            div_done;
  logic [AKW-1:0]  div_quot;
  logic            div_rem_nz;
  logic [AKW:0]    segs;
  logic [WW-1:0]   div_sample;

  pdew_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_q.acked_bytes),
    .divisor_i  (item_q.segment_size),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  assign segs = {1'b0, div_quot} + (AKW + 1)'(div_rem_nz);
  assign div_sample = ((segs != '0) && (segs < (AKW + 1)'(item_q.peak_cwnd)))
                    ? segs[WW-1:0] : item_q.peak_cwnd;

  // search
  logic issue;
  logic match;
  logic discard;

  assign issue   = (idx_q < fill_q);
  assign match   = pend_q && (rd_entry.key == item_q.dest_addr);
  assign discard = (item_q.acked_bytes < min_ack_q);
  assign div_start = (state_q == ST_PREP) && !discard && (item_q.segment_size != '0);

  // estimate update
  logic [SW-1:0]        sh_eff;
  logic [XW-1:0]        s_fix;
  logic signed [XW:0]   diff_s;
  logic signed [XW:0]   step_s;
  logic signed [XW:0]   sum_s;
  logic [XW-1:0]        est_new;

  assign sh_eff  = (shift_q > pdew_pkg::SHIFT_MAX) ? pdew_pkg::SHIFT_MAX : shift_q;
  assign s_fix   = {sample_q, FW'(0)};
  assign diff_s  = $signed({1'b0, s_fix}) - $signed({1'b0, rec_q.estimate});
  assign step_s  = diff_s >>> sh_eff;
  assign sum_s   = $signed({1'b0, rec_q.estimate}) + step_s;
  assign est_new = (rec_q.samples == '0) ? s_fix : sum_s[XW-1:0];

  // rounding and clamp
  logic [WW-1:0] rnd;
  logic [WW-1:0] lo;
  logic [WW-1:0] hi;
  logic [WW-1:0] clamped;
  logic [WW-1:0] win;

  assign rnd     = rec_q.estimate[XW-1:FW] + WW'(rec_q.estimate[FW-1]);
  assign lo      = (floor_q == '0) ? WW'(1) : floor_q;
  assign hi      = (ceil_q < lo) ? lo : ceil_q;
  assign clamped = (rnd < lo) ? lo : ((rnd > hi) ? hi : rnd);
  assign win     = sampled_q ? clamped : rec_q.window;

  always_comb begin
    wr_entry        = rec_q;
    wr_entry.window = win;
  end

  always_comb begin
    result_d = '0;
    if (full_q) begin
      result_d.table_full = 1'b1;
    end else begin
      result_d.new_window     = sampled_q ? win : WW'(0);
      result_d.discarded      = !sampled_q;
      result_d.held_window    = win;
      result_d.estimate_after = rnd;
      result_d.sample_count   = rec_q.samples;
      result_d.discard_count  = rec_q.discards;
    end
  end

  assign ram_we = (state_q == ST_FIN) && !full_q && (item_q.dest_addr != '0);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      zvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          pend_q <= issue;
          if (issue) begin
            idx_q <= idx_q + (AW + 1)'(1);
          end
          if (match) begin
            state_q <= ST_PREP;
          end else if (!pend_q && !issue) begin
            if (fill_q == DEPTH_CNT) begin
              state_q <= ST_FIN;
            end else begin
              if (item_q.dest_addr != '0) begin
                fill_q   <= fill_q + (AW + 1)'(1);
                zvalid_q <= 1'b0;
              end
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          if (discard) begin
            state_q <= ST_FIN;
          end else if (item_q.segment_size == '0) begin
            state_q <= ST_UPD;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!full_q && (item_q.dest_addr == '0)) begin
            zvalid_q <= 1'b1;
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_q    <= item_i;
          full_q    <= 1'b0;
          sampled_q <= 1'b0;
        end
      end
      ST_SEARCH: begin
        cmp_idx_q <= idx_q[AW-1:0];
        if (match) begin
          rec_q  <= rd_entry;
          slot_q <= cmp_idx_q;
        end else if (!pend_q && !issue) begin
          slot_q <= fill_q[AW-1:0];
          if (fill_q == DEPTH_CNT) begin
            full_q <= 1'b1;
          end else if ((item_q.dest_addr == '0) && zvalid_q) begin
            rec_q <= zrec_q;
          end else begin
            rec_q <= {item_q.dest_addr, {(EW - KW){1'b0}}};
          end
        end
      end
      ST_PREP: begin
        if (discard) begin
          rec_q.discards <= rec_q.discards + NW'(1);
        end else if (item_q.segment_size == '0) begin
          sample_q <= item_q.peak_cwnd;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sample_q <= div_sample;
        end
      end
      ST_UPD: begin
        rec_q     <= {rec_q.key, rec_q.samples + NW'(1), rec_q.discards, est_new,
                      rec_q.window};
        sampled_q <= 1'b1;
      end
      ST_FIN: begin
        if (!full_q && (item_q.dest_addr == '0)) begin
          zrec_q <= wr_entry;
        end
        result_q <= result_d;
      end
      default: ;
    endcase
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire
